/* rtl/core/nows_pkg.sv */
// shared types and constants for the nearest onward waypoint search
`default_nettype none

package nows_pkg;

    localparam int unsigned MAX_WAYPOINTS_DEF = 64;
    localparam int unsigned COORD_W           = 16;
    localparam int unsigned DIFF_W            = COORD_W + 1;
    localparam int unsigned SQ_W              = 2 * COORD_W;
    localparam int unsigned DIST_W            = SQ_W + 1;
    localparam int unsigned OUT_IDX_W         = 6;
    localparam int unsigned FUNC_W            = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_QUERY  = 2'd2
    } func_t;

    // what a distance computation is for
    typedef enum logic [1:0] {
        KIND_SCAN    = 2'd0,
        KIND_LATER   = 2'd1,
        KIND_BETWEEN = 2'd2
    } dist_kind_t;

    // request going into the distance unit, index travels alongside
    typedef struct packed {
        logic       valid;
        dist_kind_t kind;
    } dist_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/nows_dist_unit.sv */
// two-stage squared euclidean distance unit with a travelling tag
`default_nettype none

module nows_dist_unit #(
    parameter int unsigned IDX_W = 6
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire nows_pkg::dist_ctl_t                  in_ctl,
    input  wire logic [IDX_W-1:0]                     in_idx,
    input  wire logic signed [nows_pkg::COORD_W-1:0]  ax,
    input  wire logic signed [nows_pkg::COORD_W-1:0]  ay,
    input  wire logic signed [nows_pkg::COORD_W-1:0]  bx,
    input  wire logic signed [nows_pkg::COORD_W-1:0]  by,
    output nows_pkg::dist_ctl_t                       out_ctl,
    output logic [IDX_W-1:0]                          out_idx,
    output logic [nows_pkg::DIST_W-1:0]               sum_sq
);

    logic signed [nows_pkg::DIFF_W-1:0]     dx;
    logic signed [nows_pkg::DIFF_W-1:0]     dy;
    logic signed [2*nows_pkg::DIFF_W-1:0]   px;
    logic signed [2*nows_pkg::DIFF_W-1:0]   py;

    logic [nows_pkg::SQ_W-1:0]   sq_x_reg;
    logic [nows_pkg::SQ_W-1:0]   sq_y_reg;
    nows_pkg::dist_ctl_t         s1_ctl_reg;
    logic [IDX_W-1:0]            s1_idx_reg;
    nows_pkg::dist_ctl_t         s2_ctl_reg;
    logic [IDX_W-1:0]            s2_idx_reg;
    logic [nows_pkg::DIST_W-1:0] dist_reg;

    // differences are exact in one extra bit, squares fit the unsigned width
    assign dx = nows_pkg::DIFF_W'(ax) - nows_pkg::DIFF_W'(bx);
    assign dy = nows_pkg::DIFF_W'(ay) - nows_pkg::DIFF_W'(by);
    assign px = dx * dx;
    assign py = dy * dy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s1_idx_reg <= '0;
            s2_idx_reg <= '0;
            sq_x_reg   <= '0;
            sq_y_reg   <= '0;
            dist_reg   <= '0;
        end
        else
        begin
            // stage 1: square both differences
            s1_ctl_reg <= in_ctl;
            s1_idx_reg <= in_idx;
            sq_x_reg   <= px[nows_pkg::SQ_W-1:0];
            sq_y_reg   <= py[nows_pkg::SQ_W-1:0];
            // stage 2: sum
            s2_ctl_reg <= s1_ctl_reg;
            s2_idx_reg <= s1_idx_reg;
            dist_reg   <= nows_pkg::DIST_W'(sq_x_reg) + nows_pkg::DIST_W'(sq_y_reg);
        end
    end

    assign out_ctl = s2_ctl_reg;
    assign out_idx = s2_idx_reg;
    assign sum_sq  = dist_reg;

endmodule

`default_nettype wire

/* rtl/core/nearest_onward_waypoint_search.sv */
// top level: waypoint path store and nearest onward waypoint search sequencer
// clear, append and ignored codes finish without raising busy; a query scans each stored
// waypoint, then does the memory read, the distance unit and the onward check, with no
// onward distances if the last waypoint is nearest; an empty path answers the next cycle
// reset clears the count and overflow flag; the store itself is not cleared
// results are pulsed on done for one cycle as busy drops; the receiver cannot stall
`default_nettype none

module nearest_onward_waypoint_search #(
    parameter int unsigned MAX_WAYPOINTS = nows_pkg::MAX_WAYPOINTS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [nows_pkg::FUNC_W-1:0]          func,
    input  wire logic signed [nows_pkg::COORD_W-1:0]  query_x,
    input  wire logic signed [nows_pkg::COORD_W-1:0]  query_y,
    output logic                                      done,
    output logic [nows_pkg::OUT_IDX_W-1:0]            onward_index,
    output logic                                      path_empty,
    output logic                                      overflowed
);

    localparam int unsigned AW  = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int unsigned CW  = $clog2(MAX_WAYPOINTS + 1);
    localparam int unsigned PW  = 2 * nows_pkg::COORD_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_ONW_CHK,
        ST_ONW_BEST,
        ST_ONW_WAIT
    } state_t;

    state_t state_reg;

    // path store, x in the upper half and y in the lower half
    logic [PW-1:0] wp_mem [MAX_WAYPOINTS];
    logic [PW-1:0] rd_data_reg;

    logic [CW-1:0]                          count_reg;
    logic                                   ovf_reg;
    logic signed [nows_pkg::COORD_W-1:0]    q_x_reg;
    logic signed [nows_pkg::COORD_W-1:0]    q_y_reg;
    logic [AW-1:0]                          issue_idx_reg;
    logic [AW-1:0]                          last_idx_reg;
    logic [AW-1:0]                          best_reg;
    logic [nows_pkg::DIST_W-1:0]            best_d_reg;
    logic [nows_pkg::DIST_W-1:0]            later_d_reg;
    logic signed [nows_pkg::COORD_W-1:0]    nx_x_reg;
    logic signed [nows_pkg::COORD_W-1:0]    nx_y_reg;

    // read pipeline stage beside the memory
    nows_pkg::dist_ctl_t rd_ctl_reg;
    logic [AW-1:0]       rd_idx_reg;

    logic                               done_reg;
    logic [nows_pkg::OUT_IDX_W-1:0]     onward_index_reg;
    logic                               path_empty_reg;
    logic                               overflowed_reg;

    // read request for this cycle
    logic                   rd_issue;
    logic [AW-1:0]          rd_addr;
    nows_pkg::dist_kind_t   rd_kind;

    logic                   accept;
    logic                   not_full;
    logic                   wr_en;
    logic [AW-1:0]          nx_idx;
    logic                   onward_ok;

    // distance unit hookup
    logic signed [nows_pkg::COORD_W-1:0]  u_ax;
    logic signed [nows_pkg::COORD_W-1:0]  u_ay;
    logic signed [nows_pkg::COORD_W-1:0]  u_bx;
    logic signed [nows_pkg::COORD_W-1:0]  u_by;
    nows_pkg::dist_ctl_t                  u_out_ctl;
    logic [AW-1:0]                        u_out_idx;
    logic [nows_pkg::DIST_W-1:0]          u_dist;
    logic                                 scan_hit;

    // low output bits of a path index, zero-extended when the index is narrow
    function automatic logic [nows_pkg::OUT_IDX_W-1:0] low_index(input logic [AW-1:0] idx);
        logic [AW+nows_pkg::OUT_IDX_W-1:0] wide;
        wide = (AW + nows_pkg::OUT_IDX_W)'(idx);
        return wide[nows_pkg::OUT_IDX_W-1:0];
    endfunction

    assign accept    = start && (state_reg == ST_IDLE);
    assign not_full  = count_reg < CW'(MAX_WAYPOINTS);
    assign wr_en     = accept && (func == nows_pkg::FUNC_APPEND) && not_full;
    assign nx_idx    = best_reg + AW'(1);
    assign onward_ok = (CW'(best_reg) + CW'(1)) < count_reg;

    always_comb
    begin
        rd_issue = 1'b0;
        rd_addr  = issue_idx_reg;
        rd_kind  = nows_pkg::KIND_SCAN;
        unique case (state_reg)
            ST_SCAN:
            begin
                rd_issue = 1'b1;
            end
            ST_ONW_CHK:
            begin
                // fetch the next waypoint first so it can be held for the between distance
                rd_issue = onward_ok;
                rd_addr  = nx_idx;
                rd_kind  = nows_pkg::KIND_LATER;
            end
            ST_ONW_BEST:
            begin
                rd_issue = 1'b1;
                rd_addr  = best_reg;
                rd_kind  = nows_pkg::KIND_BETWEEN;
            end
            default:
            begin
                rd_issue = 1'b0;
            end
        endcase
    end

    // store with one write port and one read port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wp_mem[count_reg[AW-1:0]] <= {query_x, query_y};
        end
        rd_data_reg <= wp_mem[rd_addr];
    end

    // between distance measures the best waypoint against the held next one
    assign u_ax = rd_data_reg[PW-1:nows_pkg::COORD_W];
    assign u_ay = rd_data_reg[nows_pkg::COORD_W-1:0];
    assign u_bx = (rd_ctl_reg.kind == nows_pkg::KIND_BETWEEN) ? nx_x_reg : q_x_reg;
    assign u_by = (rd_ctl_reg.kind == nows_pkg::KIND_BETWEEN) ? nx_y_reg : q_y_reg;

    nows_dist_unit #(
        .IDX_W (AW)
    ) u_dist_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (rd_ctl_reg),
        .in_idx  (rd_idx_reg),
        .ax      (u_ax),
        .ay      (u_ay),
        .bx      (u_bx),
        .by      (u_by),
        .out_ctl (u_out_ctl),
        .out_idx (u_out_idx),
        .sum_sq  (u_dist)
    );

    assign scan_hit = u_out_ctl.valid && (u_out_ctl.kind == nows_pkg::KIND_SCAN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            q_x_reg          <= '0;
            q_y_reg          <= '0;
            issue_idx_reg    <= '0;
            last_idx_reg     <= '0;
            best_reg         <= '0;
            best_d_reg       <= '0;
            later_d_reg      <= '0;
            nx_x_reg         <= '0;
            nx_y_reg         <= '0;
            rd_ctl_reg       <= '0;
            rd_idx_reg       <= '0;
            done_reg         <= 1'b0;
            onward_index_reg <= '0;
            path_empty_reg   <= 1'b0;
            overflowed_reg   <= 1'b0;
        end
        else
        begin
            done_reg         <= 1'b0;
            rd_ctl_reg.valid <= rd_issue;
            rd_ctl_reg.kind  <= rd_kind;
            rd_idx_reg       <= rd_addr;

            // hold the next waypoint as it leaves the store
            if (rd_ctl_reg.valid && (rd_ctl_reg.kind == nows_pkg::KIND_LATER))
            begin
                nx_x_reg <= u_ax;
                nx_y_reg <= u_ay;
            end

            // running minimum, strict less keeps the lowest index on ties
            if (scan_hit && ((u_out_idx == '0) || (u_dist < best_d_reg)))
            begin
                best_reg   <= u_out_idx;
                best_d_reg <= u_dist;
            end

            if (u_out_ctl.valid && (u_out_ctl.kind == nows_pkg::KIND_LATER))
            begin
                later_d_reg <= u_dist;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        case (func)
                            nows_pkg::FUNC_CLEAR:
                            begin
                                count_reg <= '0;
                                ovf_reg   <= 1'b0;
                            end
                            nows_pkg::FUNC_APPEND:
                            begin
                                if (not_full)
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                                else
                                begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            nows_pkg::FUNC_QUERY:
                            begin
                                if (count_reg == '0)
                                begin
                                    // empty path answers at once
                                    done_reg         <= 1'b1;
                                    onward_index_reg <= '0;
                                    path_empty_reg   <= 1'b1;
                                    overflowed_reg   <= ovf_reg;
                                end
                                else
                                begin
                                    q_x_reg       <= query_x;
                                    q_y_reg       <= query_y;
                                    issue_idx_reg <= '0;
                                    last_idx_reg  <= AW'(count_reg - CW'(1));
                                    state_reg     <= ST_SCAN;
                                end
                            end
                            default:
                            begin
                                // unused code, no item
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    // one waypoint read per cycle
                    issue_idx_reg <= issue_idx_reg + AW'(1);
                    if (issue_idx_reg == last_idx_reg)
                    begin
                        state_reg <= ST_SCAN_WAIT;
                    end
                end
                ST_SCAN_WAIT:
                begin
                    if (scan_hit && (u_out_idx == last_idx_reg))
                    begin
                        state_reg <= ST_ONW_CHK;
                    end
                end
                ST_ONW_CHK:
                begin
                    if (onward_ok)
                    begin
                        state_reg <= ST_ONW_BEST;
                    end
                    else
                    begin
                        // nearest is the last waypoint
                        done_reg         <= 1'b1;
                        onward_index_reg <= low_index(best_reg);
                        path_empty_reg   <= 1'b0;
                        overflowed_reg   <= ovf_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                ST_ONW_BEST:
                begin
                    state_reg <= ST_ONW_WAIT;
                end
                ST_ONW_WAIT:
                begin
                    if (u_out_ctl.valid && (u_out_ctl.kind == nows_pkg::KIND_BETWEEN))
                    begin
                        // move on when the next waypoint is nearer the query than the gap
                        done_reg         <= 1'b1;
                        onward_index_reg <= (later_d_reg < u_dist) ? low_index(nx_idx)
                                                                   : low_index(best_reg);
                        path_empty_reg   <= 1'b0;
                        overflowed_reg   <= ovf_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign onward_index = onward_index_reg;
    assign path_empty   = path_empty_reg;
    assign overflowed   = overflowed_reg;

endmodule

`default_nettype wire

/* verif/testbench.sv */
// self-checking testbench for the nearest onward waypoint search, random and directed items
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD   = 10;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned PATH_DEPTH   = nows_pkg::MAX_WAYPOINTS_DEF;
    localparam int unsigned RANDOM_ITEMS = 360;
    localparam int unsigned MAX_REPORTED = 10;
    // drain time long enough to cover any item still in flight
    localparam int unsigned DRAIN_CYCLES = 2 * PATH_DEPTH + 40;
    // hang guard limit, well above the slowest correct run
    localparam int unsigned TIMEOUT_NS   = 4_000_000;

    // func code 3 is not used by the block, it must be swallowed without a result
    localparam logic [nows_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef logic signed [nows_pkg::COORD_W-1:0] coord_t;

    // one command item waiting for the driver, with the sender idle rate of its phase
    typedef struct {
        logic [nows_pkg::FUNC_W-1:0] code;
        coord_t                      x;
        coord_t                      y;
        int unsigned                 idle_pct;
    } command_t;

    // one predicted query answer
    typedef struct {
        logic [nows_pkg::OUT_IDX_W-1:0] index;
        logic                           empty;
        logic                           lost;
    } answer_t;

    // dut signals, every input known from time zero
    logic                           clk     = 1'b0;
    logic                           rst_n   = 1'b0;
    logic                           start   = 1'b0;
    logic [nows_pkg::FUNC_W-1:0]    func    = nows_pkg::FUNC_CLEAR;
    coord_t                         query_x = '0;
    coord_t                         query_y = '0;
    logic                           busy;
    logic                           done;
    logic [nows_pkg::OUT_IDX_W-1:0] onward_index;
    logic                           path_empty;
    logic                           overflowed;

    // items still to be sent and answers still to be seen
    command_t pending_items [$];
    answer_t  expected_answers [$];
    command_t next_cmd;
    answer_t  seen_answer;
    int unsigned error_count = 0;

    // predicted path held by the block
    coord_t      path_x [PATH_DEPTH];
    coord_t      path_y [PATH_DEPTH];
    int unsigned path_len    = 0;
    logic        append_lost = 1'b0;

    // stimulus bookkeeping
    int unsigned idle_now      = 10;
    int unsigned counted_items = 0;
    bit          overflow_done = 1'b0;

    nearest_onward_waypoint_search u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .query_x      (query_x),
        .query_y      (query_y),
        .done         (done),
        .onward_index (onward_index),
        .path_empty   (path_empty),
        .overflowed   (overflowed)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------- prediction

    // exact squared distance, never exceeds 33 bits
    function automatic longint unsigned span_sq(coord_t ax, coord_t ay, coord_t bx, coord_t by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return dx * dx + dy * dy;
    endfunction

    // first nearest waypoint, moved on by one when the next one lies closer to the
    // query than to the nearest
    function automatic answer_t nearest_onward(coord_t qx, coord_t qy);
        answer_t           ans;
        int unsigned       best;
        int unsigned       i;
        longint unsigned   best_d;
        longint unsigned   d;
        longint unsigned   later;
        longint unsigned   between;
        ans.lost  = append_lost;
        ans.empty = (path_len == 0);
        ans.index = '0;
        if (path_len != 0)
        begin
            best   = 0;
            best_d = span_sq(path_x[0], path_y[0], qx, qy);
            for (i = 1; i < path_len; i++)
            begin
                d = span_sq(path_x[i], path_y[i], qx, qy);
                // strict compare keeps the lowest index on a tie
                if (d < best_d)
                begin
                    best_d = d;
                    best   = i;
                end
            end
            if (best + 1 < path_len)
            begin
                later   = span_sq(path_x[best + 1], path_y[best + 1], qx, qy);
                between = span_sq(path_x[best], path_y[best],
                                  path_x[best + 1], path_y[best + 1]);
                if (later < between)
                    best = best + 1;
            end
            ans.index = best[nows_pkg::OUT_IDX_W-1:0];
        end
        return ans;
    endfunction

    // apply one accepted item to the predicted path, queue an answer for a query
    function automatic void take_item(logic [nows_pkg::FUNC_W-1:0] code, coord_t x, coord_t y);
        case (code)
            nows_pkg::FUNC_CLEAR:
            begin
                // stores keep their contents, only count and flag go
                path_len    = 0;
                append_lost = 1'b0;
            end
            nows_pkg::FUNC_APPEND:
            begin
                if (path_len < PATH_DEPTH)
                begin
                    path_x[path_len] = x;
                    path_y[path_len] = y;
                    path_len++;
                end
                else
                begin
                    // full path drops the waypoint and remembers it
                    append_lost = 1'b1;
                end
            end
            nows_pkg::FUNC_QUERY:
            begin
                expected_answers = {expected_answers, nearest_onward(x, y)};
            end
            default: ;
        endcase
    endfunction

    function automatic void report_failure(string msg);
        error_count++;
        if (error_count <= MAX_REPORTED)
            $display("error at %0t ns: %s", $time, msg);
    endfunction

    // ---------------------------------------------------------------- driver

    // an item goes across at an edge with start high and busy low; the next one is
    // put up at that same edge unless the sender idles this cycle
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                take_item(func, query_x, query_y);
            if (!start || !busy)
            begin
                if (pending_items.size() != 0 &&
                    $urandom_range(0, 99) >= pending_items[0].idle_pct)
                begin
                    next_cmd = pending_items.pop_front();
                    start   <= 1'b1;
                    func    <= next_cmd.code;
                    query_x <= next_cmd.x;
                    query_y <= next_cmd.y;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    // done is a one-cycle strobe, every strobe is an answer
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                report_failure($sformatf("unexpected answer: index %0d empty %0b overflow %0b",
                                         onward_index, path_empty, overflowed));
            end
            else
            begin
                seen_answer = expected_answers.pop_front();
                if (onward_index !== seen_answer.index || path_empty !== seen_answer.empty ||
                    overflowed !== seen_answer.lost)
                    report_failure($sformatf(
                        "expected index %0d empty %0b overflow %0b, got %0d %0b %0b",
                        seen_answer.index, seen_answer.empty, seen_answer.lost,
                        onward_index, path_empty, overflowed));
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic void queue_item(logic [nows_pkg::FUNC_W-1:0] code, coord_t x, coord_t y);
        command_t c;
        c.code     = code;
        c.x        = x;
        c.y        = y;
        c.idle_pct = idle_now;
        pending_items = {pending_items, c};
        // ignored codes do not count toward the item budget
        if (code != FUNC_UNUSED)
            counted_items++;
    endfunction

    // spread 0 means the whole coordinate range, otherwise a box around the origin, with the range extremes mixed in
    function automatic coord_t pick_coord(int unsigned spread);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return coord_t'(16'sh8000);
        if (roll < 8)
            return coord_t'(16'sh7fff);
        if (spread == 0)
            return coord_t'($urandom);
        return coord_t'(int'($urandom_range(0, 2 * spread)) - int'(spread));
    endfunction

    // clear, a fresh path, then queries aimed at it
    function automatic void build_path_run();
        int unsigned len;
        int unsigned spread;
        int unsigned queries;
        int unsigned k;
        int unsigned q;
        int unsigned roll;
        coord_t      wx [$];
        coord_t      wy [$];
        coord_t      x;
        coord_t      y;
        roll = $urandom_range(0, 99);
        if (!overflow_done)
        begin
            // one guaranteed run past capacity so dropped appends are seen
            len           = PATH_DEPTH + 3;
            overflow_done = 1'b1;
        end
        else if (roll < 65)
            len = $urandom_range(0, 10);
        else if (roll < 85)
            len = $urandom_range(11, PATH_DEPTH - 2);
        else
            len = $urandom_range(PATH_DEPTH - 2, PATH_DEPTH + 6);
        spread = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(8, 3000);
        queue_item(nows_pkg::FUNC_CLEAR, pick_coord(0), pick_coord(0));
        for (k = 0; k < len; k++)
        begin
            // repeated points give distance ties
            if (wx.size() != 0 && $urandom_range(0, 9) == 0)
            begin
                x = wx[wx.size() - 1];
                y = wy[wy.size() - 1];
            end
            else
            begin
                x = pick_coord(spread);
                y = pick_coord(spread);
            end
            wx = {wx, x};
            wy = {wy, y};
            queue_item(nows_pkg::FUNC_APPEND, x, y);
        end
        queries = $urandom_range(1, 6);
        for (q = 0; q < queries; q++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30 || wx.size() == 0)
            begin
                x = pick_coord(spread);
                y = pick_coord(spread);
            end
            else if (roll < 65 || wx.size() < 2)
            begin
                // close to a stored waypoint
                k = $urandom_range(0, wx.size() - 1);
                x = coord_t'(int'(wx[k]) + int'($urandom_range(0, 40)) - 20);
                y = coord_t'(int'(wy[k]) + int'($urandom_range(0, 40)) - 20);
            end
            else
            begin
                // around the midpoint of a segment, where the onward step decides
                k = $urandom_range(0, wx.size() - 2);
                x = coord_t'((int'(wx[k]) + int'(wx[k + 1])) / 2 + int'($urandom_range(0, 8)) - 4);
                y = coord_t'((int'(wy[k]) + int'(wy[k + 1])) / 2 + int'($urandom_range(0, 8)) - 4);
            end
            queue_item(nows_pkg::FUNC_QUERY, x, y);
        end
    endfunction

    // out-of-order items of any code, including the unused one
    function automatic void add_noise();
        int unsigned n;
        int unsigned k;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
            queue_item(logic'($urandom_range(0, 3)) ? 2'($urandom_range(0, 3))
                                                    : nows_pkg::FUNC_QUERY,
                       pick_coord(0), pick_coord(0));
    endfunction

    initial
    begin
        int unsigned directed_count;
        int unsigned random_done;

        // directed: empty path, coordinate extremes, ties, onward step, unused code
        idle_now = 10;
        queue_item(nows_pkg::FUNC_CLEAR, 16'sh0000, 16'sh0000);
        queue_item(nows_pkg::FUNC_QUERY, 16'sh0000, 16'sh0000);
        queue_item(FUNC_UNUSED, 16'sh7fff, 16'sh8000);
        queue_item(nows_pkg::FUNC_APPEND, 16'sh8000, 16'sh8000);
        queue_item(nows_pkg::FUNC_QUERY, 16'sh7fff, 16'sh7fff);
        queue_item(nows_pkg::FUNC_APPEND, 16'sh7fff, 16'sh7fff);
        queue_item(nows_pkg::FUNC_QUERY, 16'sh0000, 16'sh0000);
        queue_item(nows_pkg::FUNC_QUERY, 16'sh8000, 16'sh8000);
        queue_item(nows_pkg::FUNC_QUERY, 16'sh7fff, 16'sh8000);
        queue_item(nows_pkg::FUNC_QUERY, 16'sh8000, 16'sh7fff);
        queue_item(nows_pkg::FUNC_APPEND, 16'sh7fff, 16'sh7fff);
        queue_item(nows_pkg::FUNC_QUERY, 16'sh7fff, 16'sh7fff);
        queue_item(nows_pkg::FUNC_APPEND, 16'sh0000, 16'sh0000);
        queue_item(nows_pkg::FUNC_QUERY, 16'sh0064, 16'sh0064);
        queue_item(nows_pkg::FUNC_QUERY, 16'sh4000, 16'sh4000);
        queue_item(nows_pkg::FUNC_QUERY, 16'shc000, 16'shc001);
        queue_item(FUNC_UNUSED, 16'sh0000, 16'sh0000);
        queue_item(nows_pkg::FUNC_QUERY, 16'shffff, 16'sh0001);
        queue_item(nows_pkg::FUNC_CLEAR, 16'sh7fff, 16'sh7fff);
        queue_item(nows_pkg::FUNC_QUERY, 16'sh1234, 16'shedcb);
        directed_count = counted_items;

        // random part in three idle phases: light, heavy, none
        while (counted_items < directed_count + RANDOM_ITEMS)
        begin
            random_done = counted_items - directed_count;
            if (random_done < RANDOM_ITEMS / 3)
                idle_now = 10;
            else if (random_done < 2 * RANDOM_ITEMS / 3)
                idle_now = 77;
            else
                idle_now = 0;
            if ($urandom_range(0, 99) < 80)
                build_path_run();
            else
                add_noise();
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // all items taken, all answers in, then let any last item settle
        while (pending_items.size() != 0 || start)
            @(posedge clk);
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hang guard
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d answers outstanding", expected_answers.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
